// ----- sv/idq_pkg.sv -----
// Shared types, register indexes and format helpers for the int4 group
// dequantising dot-row block. No dependencies.
package idq_pkg;

  typedef enum logic {
    OP_MUL,
    OP_ADD
  } fp_op_t;

  typedef enum logic [1:0] {
    REG_SCHEME    = 2'd0,
    REG_ZEROS     = 2'd1,
    REG_GROUP     = 2'd2,
    REG_ROW_LEN   = 2'd3
  } reg_idx_t;

  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] F32_POS_ZERO = 32'h0000_0000;
  localparam logic [7:0]  F32_EXP_MAX  = 8'hFF;
  localparam logic [3:0]  NIBBLE_MASK  = 4'hF;
  localparam logic [4:0]  SYM_OFFSET   = 5'd7;

  // Exact conversion of a half-precision pattern to single precision.
  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic       sgn;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] k;
    logic [9:0] fr;
    logic [31:0] res;
    sgn = h[15];
    ex  = h[14:10];
    man = h[9:0];
    k   = 4'd0;
    fr  = 10'd0;
    if (ex == 5'h1F) begin
      res = {sgn, 8'hFF, man, 13'd0};
    end else if (ex != 5'd0) begin
      res = {sgn, 8'(ex) + 8'd112, man, 13'd0};
    end else if (man == 10'd0) begin
      res = {sgn, 31'd0};
    end else begin
      for (int i = 0; i < 10; i++) begin
        if (man[i]) k = 4'(i);
      end
      fr  = man << (4'd10 - k);
      res = {sgn, 8'd103 + 8'(k), fr, 13'd0};
    end
    return res;
  endfunction

  // The weight nibble, optionally less the symmetric offset, as an exact float.
  function automatic logic [31:0] nibble_to_f32(input logic [3:0] q, input logic sub7);
    logic signed [5:0] v;
    logic        sgn;
    logic [3:0]  mag;
    logic [1:0]  k;
    logic [22:0] fr;
    logic [31:0] res;
    v   = $signed({2'b00, q & NIBBLE_MASK}) - (sub7 ? $signed({1'b0, SYM_OFFSET}) : 6'sd0);
    sgn = v[5];
    mag = sgn ? 4'(-v) : 4'(v);
    k   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (mag[i]) k = 2'(i);
    end
    fr  = 23'({19'd0, mag} << (5'd23 - 5'(k)));
    res = (mag == 4'd0) ? F32_POS_ZERO : {sgn, 8'd127 + 8'(k), fr};
    return res;
  endfunction

endpackage

// ----- sv/idq_ifs.sv -----
// Handshake channel interfaces for the element requests and the row results.
// Depends on nothing.
interface idq_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] act_bits;
  logic [3:0]  weight_nibble;
  logic [15:0] scale_bits;
  logic [15:0] zero_bits;
  modport source (output valid, act_bits, weight_nibble, scale_bits, zero_bits, input ready);
  modport sink (input valid, act_bits, weight_nibble, scale_bits, zero_bits, output ready);
endinterface

interface idq_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_value;
  logic [15:0] row_number;
  logic        was_nonfinite;
  modport source (output valid, row_value, row_number, was_nonfinite, input ready);
  modport sink (input valid, row_value, row_number, was_nonfinite, output ready);
endinterface

// ----- sv/idq_fpu.sv -----
// Shared binary32 multiply / add unit, two register stages, round to nearest even.
// Depends on idq_pkg.
module idq_fpu (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  idq_pkg::fp_op_t op,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output logic [31:0]     result,
  output logic            done
);
  import idq_pkg::*;

  // Unrounded value: m * 2^e, or a ready-made special pattern.
  typedef struct packed {
    logic               special;
    logic [31:0]        spec_bits;
    logic               sgn;
    logic signed [10:0] e;
    logic [48:0]        m;
  } unr_t;

  unr_t ua, ur;
  logic stage_a;

  logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0] ma, mb;
  logic [47:0] mul_m;
  logic signed [10:0] ea, eb;

  assign sa     = a[31];
  assign sb     = b[31];
  assign nan_a  = (a[30:23] == F32_EXP_MAX) && (a[22:0] != 23'd0);
  assign nan_b  = (b[30:23] == F32_EXP_MAX) && (b[22:0] != 23'd0);
  assign inf_a  = (a[30:23] == F32_EXP_MAX) && (a[22:0] == 23'd0);
  assign inf_b  = (b[30:23] == F32_EXP_MAX) && (b[22:0] == 23'd0);
  assign zero_a = (a[30:0] == 31'd0);
  assign zero_b = (b[30:0] == 31'd0);
  assign ma     = {a[30:23] != 8'd0, a[22:0]};
  assign mb     = {b[30:23] != 8'd0, b[22:0]};
  assign mul_m  = ma * mb;
  assign ea     = $signed({3'b000, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - 11'sd150;
  assign eb     = $signed({3'b000, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - 11'sd150;

  logic               swap;
  logic signed [10:0] e_big, e_sml;
  logic [23:0]        m_big, m_sml;
  logic               s_big;
  logic [10:0]        align_sh;
  logic [26:0]        sml_ext, sml_sh;
  logic               sml_st;
  logic [27:0]        opa, opb;
  logic [28:0]        sum;

  always_comb begin
    swap     = b[30:0] > a[30:0];
    e_big    = swap ? eb : ea;
    e_sml    = swap ? ea : eb;
    m_big    = swap ? mb : ma;
    m_sml    = swap ? ma : mb;
    s_big    = swap ? sb : sa;
    align_sh = 11'(e_big - e_sml);
    sml_ext  = {m_sml, 3'b000};
    if (align_sh >= 11'd27) begin
      sml_sh = 27'd0;
      sml_st = (m_sml != 24'd0);
    end else begin
      sml_sh = sml_ext >> align_sh;
      sml_st = |(sml_ext & ((27'd1 << align_sh) - 27'd1));
    end
    opa = {m_big, 3'b000, 1'b0};
    opb = {sml_sh, sml_st};
    sum = (sa == sb) ? ({1'b0, opa} + {1'b0, opb}) : ({1'b0, opa} - {1'b0, opb});

    ua = '0;
    if (op == OP_MUL) begin
      if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
        ua.special   = 1'b1;
        ua.spec_bits = F32_QNAN;
      end else if (inf_a || inf_b) begin
        ua.special   = 1'b1;
        ua.spec_bits = {sa ^ sb, F32_EXP_MAX, 23'd0};
      end else begin
        ua.sgn = sa ^ sb;
        ua.e   = ea + eb - 11'sd1;
        ua.m   = {mul_m, 1'b0};
      end
    end else begin
      if (nan_a || nan_b || (inf_a && inf_b && (sa != sb))) begin
        ua.special   = 1'b1;
        ua.spec_bits = F32_QNAN;
      end else if (inf_a) begin
        ua.special   = 1'b1;
        ua.spec_bits = a;
      end else if (inf_b) begin
        ua.special   = 1'b1;
        ua.spec_bits = b;
      end else begin
        ua.sgn = (sum == 29'd0) ? (sa & sb) : s_big;
        ua.e   = e_big - 11'sd4;
        ua.m   = 49'(sum);
      end
    end
  end

  // Normalise and round the registered value.
  logic [5:0]         msb;
  logic signed [12:0] big_e, unit_e, shamt;
  logic [63:0]        mx, r, lost, half;
  logic [39:0]        packed_v;
  logic [31:0]        rounded;

  always_comb begin
    msb = 6'd0;
    for (int i = 0; i < 49; i++) begin
      if (ur.m[i]) msb = 6'(i);
    end
    big_e  = 13'(ur.e) + $signed({7'd0, msb});
    unit_e = (big_e - 13'sd23 < -13'sd149) ? -13'sd149 : big_e - 13'sd23;
    shamt  = unit_e - 13'(ur.e);
    mx     = {15'd0, ur.m};
    lost   = 64'd0;
    half   = 64'd0;
    if (shamt <= 13'sd0) begin
      r = mx << 6'(-shamt);
    end else if (shamt > 13'sd63) begin
      r = 64'd0;
    end else begin
      r    = mx >> 6'(shamt);
      lost = mx & ((64'd1 << 6'(shamt)) - 64'd1);
      half = 64'd1 << 6'(shamt - 13'sd1);
      if ((lost > half) || ((lost == half) && r[0])) r = r + 64'd1;
    end
    packed_v = (40'(unit_e + 13'sd149) << 23) + 40'(r);
    if (ur.special) begin
      rounded = ur.spec_bits;
    end else if (ur.m == 49'd0) begin
      rounded = {ur.sgn, 31'd0};
    end else if (packed_v >= 40'h00_7F80_0000) begin
      rounded = {ur.sgn, F32_EXP_MAX, 23'd0};
    end else begin
      rounded = {ur.sgn, packed_v[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a <= 1'b0;
      done    <= 1'b0;
    end else begin
      stage_a <= start;
      done    <= stage_a;
    end
    if (start) ur <= ua;
    if (stage_a) result <= rounded;
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done) else $error("unit result missing two cycles after start");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 2)) else $error("unit result without a start");
  a_stage_busy: assert property (@(posedge clk) disable iff (rst)
    stage_a |-> $past(start)) else $error("first stage active without start");

endmodule

// ----- sv/int4_group_dequant_dot_row_unit.sv -----
// Top level: int4 group-quantised dot product of one row, one element per request.
// Requests are taken only while idle, so a new one waits until the last is through:
// accept, two operations of the shared float unit (symmetric, group still open) or else
// four, then close; a closing row also waits while the previous row result is still held.
// A row result is loaded from the finish state after the closing element's last operation.
// Reset (synchronous, active high) clears all sums and counters; uses idq_pkg/ifs/fpu.
module int4_group_dequant_dot_row_unit #(
  parameter int             MAX_ROW_LEN     = 16384,
  parameter int             MAX_GROUP       = 8192,
  parameter longint unsigned ROW_COUNT_RANGE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  idq_elem_if.sink    elem,
  idq_res_if.source   result
);
  import idq_pkg::*;

  localparam int EP_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int GP_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW   = (ROW_COUNT_RANGE > 1) ? $clog2(ROW_COUNT_RANGE) : 1;
  localparam logic [16:0] ROW_CAP   = 17'(MAX_ROW_LEN);
  localparam logic [16:0] GROUP_CAP = 17'(MAX_GROUP);
  localparam logic [CW-1:0] CNT_LAST = CW'(ROW_COUNT_RANGE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_FINISH
  } state_t;

  // Configuration registers over APB: the user writes them only while idle; unchecked.
  logic        scheme_symmetric, zeros_present;
  logic [13:0] grp_len;
  logic [14:0] row_length;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scheme_symmetric <= 1'b1;
      zeros_present    <= 1'b0;
      grp_len          <= 14'd128;
      row_length       <= 15'd4096;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SCHEME:  scheme_symmetric <= pwdata[0];
        REG_ZEROS:   zeros_present    <= pwdata[0];
        REG_GROUP:   grp_len          <= pwdata[13:0];
        REG_ROW_LEN: row_length       <= pwdata[14:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SCHEME:  prdata = {31'd0, scheme_symmetric};
      REG_ZEROS:   prdata = {31'd0, zeros_present};
      REG_GROUP:   prdata = {18'd0, grp_len};
      REG_ROW_LEN: prdata = {17'd0, row_length};
      default:     prdata = 32'd0;
    endcase
  end

  // Out-of-range sizes are clamped: zero acts as one, anything above the cap as the cap.
  logic [16:0] gs_eff, rl_eff;
  assign gs_eff = (grp_len == 14'd0) ? 17'd1 :
                  ({3'd0, grp_len} > GROUP_CAP) ? GROUP_CAP : {3'd0, grp_len};
  assign rl_eff = (row_length == 15'd0) ? 17'd1 :
                  ({2'd0, row_length} > ROW_CAP) ? ROW_CAP : {2'd0, row_length};

  // Sequencer and datapath state.
  state_t          state;
  logic [1:0]      step;
  logic [EP_W-1:0] element_position;
  logic [GP_W-1:0] position_in_group;
  logic [CW-1:0]   row_counter;
  logic [31:0]     row_sum, group_sum, temp;
  logic [31:0]     x_q, w_q, scale_q, zero_q;
  logic            sym_q, group_end_q, row_end_q;

  logic accept, row_end_now, group_end_now;
  assign elem.ready    = (state == S_IDLE);
  assign accept        = elem.valid && elem.ready;
  assign row_end_now   = (17'(element_position) + 17'd1) >= rl_eff;
  assign group_end_now = row_end_now || ((17'(position_in_group) + 17'd1) >= gs_eff);

  // Operation schedule. Symmetric: t = x*(q-7); g += t; then at a group close
  // t = g*scale and r += t. Zero-point: t = q*scale; t += zero; t = x*t; r += t.
  fp_op_t      fpu_op;
  logic [31:0] fpu_a, fpu_b, fpu_res;
  logic        fpu_start, fpu_done;

  always_comb begin
    fpu_op = step[0] ? OP_ADD : OP_MUL;
    fpu_a  = row_sum;
    fpu_b  = temp;
    case (step)
      2'd0: begin
        fpu_a = sym_q ? x_q : w_q;
        fpu_b = sym_q ? w_q : scale_q;
      end
      2'd1: begin
        fpu_a = sym_q ? group_sum : temp;
        fpu_b = sym_q ? temp : zero_q;
      end
      2'd2: begin
        fpu_a = sym_q ? group_sum : x_q;
        fpu_b = sym_q ? scale_q : temp;
      end
      default: begin
        fpu_a = row_sum;
        fpu_b = temp;
      end
    endcase
  end

  assign fpu_start = (state == S_ISSUE);

  idq_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .start  (fpu_start),
    .op     (fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .result (fpu_res),
    .done   (fpu_done)
  );

  // Result register: the next element request is taken while a row result waits.
  logic        res_valid, res_nonfinite;
  logic [31:0] res_value;
  logic [15:0] res_number;
  logic        sum_bad;
  logic        finish_go, res_load;

  assign result.valid         = res_valid;
  assign result.row_value     = res_value;
  assign result.row_number    = res_number;
  assign result.was_nonfinite = res_nonfinite;
  assign sum_bad              = (row_sum[30:23] == F32_EXP_MAX);
  // A row close may only proceed once the result register is free or being emptied.
  assign finish_go            = !(row_end_q && res_valid && !result.ready);
  assign res_load             = (state == S_FINISH) && row_end_q && finish_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      step              <= 2'd0;
      element_position  <= '0;
      position_in_group <= '0;
      row_counter       <= '0;
      row_sum           <= F32_POS_ZERO;
      group_sum         <= F32_POS_ZERO;
      res_valid         <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            x_q         <= elem.act_bits;
            w_q         <= nibble_to_f32(elem.weight_nibble, scheme_symmetric);
            scale_q     <= half_to_f32(elem.scale_bits);
            zero_q      <= zeros_present ? half_to_f32(elem.zero_bits) : F32_POS_ZERO;
            sym_q       <= scheme_symmetric;
            group_end_q <= group_end_now;
            row_end_q   <= row_end_now;
            step        <= 2'd0;
            state       <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (fpu_done) begin
            case (step)
              2'd1:    if (sym_q) group_sum <= fpu_res; else temp <= fpu_res;
              2'd3:    row_sum <= fpu_res;
              default: temp <= fpu_res;
            endcase
            if ((step == 2'd3) || (sym_q && (step == 2'd1) && !group_end_q)) begin
              state <= S_FINISH;
            end else begin
              step  <= step + 2'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          // A row close waits here until the result register is free or being emptied.
          if (finish_go) begin
            if (row_end_q) begin
              res_value         <= sum_bad ? F32_POS_ZERO : row_sum;
              res_nonfinite     <= sum_bad;
              res_number        <= 16'(row_counter);
              row_counter       <= (row_counter == CNT_LAST) ? '0 : row_counter + 1'b1;
              row_sum           <= F32_POS_ZERO;
              group_sum         <= F32_POS_ZERO;
              element_position  <= '0;
              position_in_group <= '0;
            end else begin
              if (group_end_q) begin
                group_sum         <= F32_POS_ZERO;
                position_in_group <= '0;
              end else begin
                position_in_group <= position_in_group + 1'b1;
              end
              element_position <= element_position + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    fpu_done |-> state == S_WAIT) else $error("float unit result outside the wait state");
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_ISSUE && step == 2'd0) else $error("request did not start a sequence");
  a_result_at_row_end: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_FINISH && row_end_q))
    else $error("row result raised without a row close");
  a_group_close_at_row_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && row_end_q) |-> group_end_q)
    else $error("row closed without closing its group");

endmodule
